[hw/rtl/i2cmbe_pkg.sv]
// Shared types and constants for the I2C master bit engine.
package i2cmbe_pkg;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_WRITE = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;
    localparam logic [2:0] ACT_FLUSH = 3'd5;

    localparam logic [15:0] DELAY_RESET = 16'd6;

    localparam logic [8:0] START_PHASES = 9'd3;
    localparam logic [8:0] STOP_PHASES  = 9'd4;
    localparam logic [8:0] WRITE_PHASES = 9'd28;
    localparam logic [8:0] READ_PHASES  = 9'd19;

    localparam logic [8:0] WR_BITS_END = 9'd24;
    localparam logic [8:0] WR_ACK_REL  = 9'd25;
    localparam logic [8:0] WR_ACK_CLK  = 9'd26;
    localparam logic [8:0] RD_BITS_END = 9'd16;
    localparam logic [8:0] RD_ACK_DRV  = 9'd17;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] write_data;
        logic       send_ack;
        logic [7:0] flush_count;
        logic       sda_in;
        logic       is_cmd;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       slave_nack;
        logic       rejected;
    } t_result;

endpackage

[hw/rtl/i2cmbe_front.sv]
// Front end: accept and classify tick items into a two-entry queue.
module i2cmbe_front import i2cmbe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [17:0] i_data,
    input  logic [2:0]  i_kind,
    output t_item       o_item,
    output logic        o_valid,
    input  logic        i_pop
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_item      w_item;
    logic       w_push;

    always_comb begin
        w_item.action      = i_kind;
        w_item.write_data  = i_data[7:0];
        w_item.send_ack    = i_data[8];
        w_item.flush_count = i_data[16:9];
        w_item.sda_in      = i_data[17];
        w_item.is_cmd      = (i_kind >= ACT_START) && (i_kind <= ACT_FLUSH);
    end

    assign o_ready = (r_count != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/i2cmbe_back.sv]
// Back end: phase sequencer for SCL/SDA and the registered result stage.
module i2cmbe_back import i2cmbe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  logic        i_valid,
    output logic        o_pop,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    output t_result     o_result,
    output logic        o_valid,
    input  logic        i_ready
);

    typedef struct packed {
        logic scl;
        logic sda;
    } t_lines;

    logic [2:0]  r_cmd,   n_cmd;
    logic [8:0]  r_step,  n_step;
    logic [15:0] r_tick,  n_tick;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_pulse, n_pulse;
    logic        r_ack,   n_ack;
    logic        r_scl,   n_scl;
    logic        r_sda,   n_sda;
    logic        r_nack,  n_nack;
    logic [7:0]  r_last,  n_last;
    logic [1:0]  r_sub,   n_sub;
    logic [2:0]  r_bit,   n_bit;
    logic [15:0] r_delay;
    logic        r_out_valid;
    t_result     r_result;
    t_result     w_result;
    logic [15:0] w_delay;
    logic [8:0]  w_step_next;
    t_lines      w_lines;

    function automatic logic [8:0] phase_total(input logic [2:0] cmd, input logic [7:0] pulses);
        logic [8:0] total;
        case (cmd)
            ACT_START: total = START_PHASES;
            ACT_STOP:  total = STOP_PHASES;
            ACT_WRITE: total = WRITE_PHASES;
            ACT_READ:  total = READ_PHASES;
            ACT_FLUSH: total = {pulses, 1'b0};
            default:   total = 9'd0;
        endcase
        return total;
    endfunction

    function automatic t_lines apply_phase(
        input logic [2:0] cmd,
        input logic [8:0] k,
        input logic [1:0] sub,
        input logic [2:0] bit_idx,
        input logic [7:0] shift,
        input logic       ack,
        input t_lines     cur
    );
        t_lines lines;
        lines = cur;
        case (cmd)
            ACT_START: begin
                if (k == 9'd1) begin
                    lines.scl = 1'b1;
                end else if (k == 9'd2) begin
                    lines.sda = 1'b0;
                end
            end
            ACT_STOP: begin
                if (k == 9'd1) begin
                    lines.sda = 1'b0;
                end else if (k == 9'd2) begin
                    lines.scl = 1'b1;
                end else if (k == 9'd3) begin
                    lines.sda = 1'b1;
                end
            end
            ACT_FLUSH: lines.scl = k[0];
            ACT_WRITE: begin
                if (k == 9'd0) begin
                    lines.scl = 1'b0;
                end else if (k <= WR_BITS_END) begin
                    if (sub == 2'd0) begin
                        lines.sda = shift[~bit_idx];
                    end else begin
                        lines.scl = (sub == 2'd1);
                    end
                end else if (k == WR_ACK_REL) begin
                    lines.sda = 1'b1;
                end else if (k == WR_ACK_CLK) begin
                    lines.scl = 1'b1;
                end else begin
                    lines.scl = 1'b0;
                end
            end
            ACT_READ: begin
                if (k < RD_BITS_END) begin
                    lines.scl = k[0];
                end else if (k == RD_BITS_END) begin
                    lines.scl = 1'b0;
                end else if (k == RD_ACK_DRV) begin
                    lines.sda = ~ack;
                end else begin
                    lines.scl = 1'b1;
                end
            end
            default: lines = cur;
        endcase
        return lines;
    endfunction

    assign o_pop       = i_valid && (!r_out_valid || i_ready);
    assign w_delay     = (r_delay == 16'd0) ? 16'd1 : r_delay;
    assign w_step_next = r_step + 9'd1;

    always_comb begin
        n_cmd   = r_cmd;
        n_step  = r_step;
        n_tick  = r_tick;
        n_shift = r_shift;
        n_pulse = r_pulse;
        n_ack   = r_ack;
        n_nack  = r_nack;
        n_last  = r_last;
        n_sub   = r_sub;
        n_bit   = r_bit;
        w_lines = '{scl: r_scl, sda: r_sda};
        w_result.rejected = 1'b0;
        w_result.done_res = 1'b0;
        if (r_cmd != ACT_NONE) begin
            w_result.rejected = i_item.is_cmd;
            if (r_tick < w_delay) begin
                n_tick = r_tick + 16'd1;
            end else begin
                if ((r_cmd == ACT_WRITE) && (r_step == WR_ACK_CLK)) begin
                    n_nack = i_item.sda_in;
                end else if ((r_cmd == ACT_READ) && (r_step < RD_BITS_END) && r_step[0]
                             && i_item.sda_in) begin
                    n_shift[~r_step[3:1]] = 1'b1;
                end
                if (w_step_next >= phase_total(r_cmd, r_pulse)) begin
                    if (r_cmd == ACT_READ) begin
                        n_last = n_shift;
                    end
                    n_cmd  = ACT_NONE;
                    n_step = 9'd0;
                    n_tick = 16'd0;
                    w_result.done_res = 1'b1;
                end else begin
                    n_step = w_step_next;
                    if (r_sub == 2'd2) begin
                        n_sub = 2'd0;
                        n_bit = r_bit + 3'd1;
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                    w_lines = apply_phase(r_cmd, n_step, n_sub, n_bit, n_shift, r_ack,
                                          '{scl: r_scl, sda: r_sda});
                    n_tick  = 16'd1;
                end
            end
        end else if (i_item.is_cmd) begin
            n_cmd   = i_item.action;
            n_step  = 9'd0;
            n_ack   = i_item.send_ack;
            n_pulse = i_item.flush_count;
            n_shift = (i_item.action == ACT_WRITE) ? i_item.write_data : 8'd0;
            n_sub   = 2'd2;
            n_bit   = 3'd7;
            if (phase_total(i_item.action, i_item.flush_count) == 9'd0) begin
                n_cmd  = ACT_NONE;
                n_tick = 16'd0;
                w_result.done_res = 1'b1;
            end else begin
                w_lines = apply_phase(i_item.action, 9'd0, n_sub, n_bit, n_shift, n_ack,
                                      '{scl: r_scl, sda: r_sda});
                n_tick  = 16'd1;
            end
        end
        n_scl = w_lines.scl;
        n_sda = w_lines.sda;
        w_result.scl_out    = n_scl;
        w_result.sda_out    = n_sda;
        w_result.busy_res   = (n_cmd != ACT_NONE);
        w_result.read_data  = n_last;
        w_result.slave_nack = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= ACT_NONE;
            r_step      <= 9'd0;
            r_tick      <= 16'd0;
            r_shift     <= 8'd0;
            r_pulse     <= 8'd0;
            r_ack       <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_nack      <= 1'b0;
            r_last      <= 8'd0;
            r_sub       <= 2'd0;
            r_bit       <= 3'd0;
            r_delay     <= DELAY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_delay <= i_cfg_data;
            end
            if (o_pop) begin
                r_cmd       <= n_cmd;
                r_step      <= n_step;
                r_tick      <= n_tick;
                r_shift     <= n_shift;
                r_pulse     <= n_pulse;
                r_ack       <= n_ack;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_nack      <= n_nack;
                r_last      <= n_last;
                r_sub       <= n_sub;
                r_bit       <= n_bit;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= w_result;
        end
    end

    assign o_result = r_result;
    assign o_valid  = r_out_valid;

endmodule

[hw/rtl/i2c_master_bit_engine.sv]
// Top level of the tick-driven I2C master bit engine.
// One tick item is taken every clock cycle while the front queue has room, and one result
// comes out per item, held first in the front queue and then in the output register.
// Each item passes once through the back end's phase sequencer, which updates SCL, SDA
// and the phase counters in the same cycle. The configuration channel is always ready;
// write delay_ticks only while no command is in progress and no result is outstanding.
module i2c_master_bit_engine import i2cmbe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // write_data[7:0], send_ack[8], flush_count[16:9], sda_in[17]
    input  logic [2:0]  s_axis_tuser,   // action[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // scl_out[0], sda_out[1], busy_res[2], done_res[3],
                                        // read_data[11:4], slave_nack[12], rejected[13]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data      // delay_ticks
);

    t_item   w_q_item;
    logic    w_q_valid;
    logic    w_q_pop;
    t_result w_result;

    i2cmbe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata[17:0]),
        .i_kind  (s_axis_tuser),
        .o_item  (w_q_item),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop)
    );

    i2cmbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_q_item),
        .i_valid     (w_q_valid),
        .o_pop       (w_q_pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_result    (w_result),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {2'b00, w_result.rejected, w_result.slave_nack, w_result.read_data,
                           w_result.done_res, w_result.busy_res, w_result.sda_out,
                           w_result.scl_out};

    a_full_needs_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("queue full without an output stall");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |-> !m_axis_tdata[2])
        else $error("result marked done and busy");

    a_result_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(w_q_valid))
        else $error("result without a queued item");

endmodule
